/* sv/assert_macros.svh */
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/hsv2rgb_pkg.sv */
`default_nettype none

package hsv2rgb_pkg;

   // Fraction bits of the Q1.FRAC_BITS inputs.
   localparam int FRAC_BITS = 16;
   localparam int FIELD_W   = FRAC_BITS + 1;
   localparam int PROD_W    = 2 * FIELD_W;
   localparam int CHAN_W    = 8;
   localparam int SECTOR_W  = 3;

   typedef logic [FIELD_W-1:0] fix_type;

   localparam fix_type ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   // Hue sectors, one sixth of a turn each.
   localparam logic [SECTOR_W-1:0] SECTOR_RED_TO_YELLOW    = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_TO_GREEN  = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_TO_CYAN    = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN_TO_BLUE     = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_TO_MAGENTA  = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_MAGENTA_TO_RED   = 3'd5;

   typedef struct packed {
      fix_type hue;
      fix_type saturation;
      fix_type brightness;
   } pixel_in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_out_type;

endpackage

`default_nettype wire

/* sv/hsv_to_rgb_pixel.sv */
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   hue, saturation, brightness (Q1.16 each)
// rsp       out        rsp_valid/rsp_stall   red, green, blue (8 bits each)
//
// Every pixel passes through all five register stages in order, from the
// transfer on req to the cycle its result is offered on rsp.
// One pixel is taken per cycle while req_stall is low; the two 17x17 multiplier stages set the clock.
// Reset is synchronous and clears only the stage valid bits.
// Each stage holds its pixel only while the stage ahead is full and stalled, so
// bubbles are squeezed out and req stalls only when all five stages are full.
`default_nettype none
`include "assert_macros.svh"

module hsv_to_rgb_pixel (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  hsv2rgb_pkg::pixel_in_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output hsv2rgb_pkg::pixel_out_type rsp_data
);
   import hsv2rgb_pkg::*;

   localparam int NUM_STAGES = 5;
   localparam int CODE_W     = CHAN_W + 2;

   // Saturate a Q1.FRAC_BITS field at 1.0.
   function automatic fix_type sat_one(input fix_type x);
      return (x > ONE_Q) ? ONE_Q : x;
   endfunction

   // Clip a channel code (at most 256) to the 8-bit range.
   function automatic logic [CHAN_W-1:0] clip_chan(input logic [CODE_W-1:0] c);
      return (c > CODE_W'(255)) ? {CHAN_W{1'b1}} : c[CHAN_W-1:0];
   endfunction

   // Stage valid bits and load enables. A stage loads when it is empty or when
   // the stage ahead of it loads, which lets bubbles collapse under a stall.
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] ld;

   always_comb begin
      ld[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
      vld_in[0] = ld[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = ld[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !ld[0];

   // Stage 1: wrap the hue, clamp saturation and value, and split 6*h into the
   // sector number and the fractional position inside that sector.
   logic [FRAC_BITS-1:0]   hue_frac;
   logic [FRAC_BITS+2:0]   hue6;
   fix_type                s1_sat_ff;
   fix_type                s1_val_ff;
   logic [SECTOR_W-1:0]    s1_sector_ff;
   logic [FRAC_BITS-1:0]   s1_frac_ff;

   always_comb begin
      hue_frac = req_data.hue[FRAC_BITS-1:0];
      hue6     = ({3'b000, hue_frac} << 2) + ({3'b000, hue_frac} << 1);
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         s1_sat_ff    <= sat_one(req_data.saturation);
         s1_val_ff    <= sat_one(req_data.brightness);
         s1_sector_ff <= hue6[FRAC_BITS +: SECTOR_W];
         s1_frac_ff   <= hue6[FRAC_BITS-1:0];
      end
   end

   // Stage 2: the products s*f and s*(1-f), floored back to Q1.FRAC_BITS.
   logic [PROD_W-1:0]      prod_sf;
   logic [PROD_W-1:0]      prod_st;
   fix_type                s2_sat_ff;
   fix_type                s2_val_ff;
   logic [SECTOR_W-1:0]    s2_sector_ff;
   fix_type                s2_sf_ff;
   fix_type                s2_st_ff;

   always_comb begin
      prod_sf = PROD_W'(s1_sat_ff) * PROD_W'({1'b0, s1_frac_ff});
      prod_st = PROD_W'(s1_sat_ff) * PROD_W'(ONE_Q - {1'b0, s1_frac_ff});
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s2_sat_ff    <= s1_sat_ff;
         s2_val_ff    <= s1_val_ff;
         s2_sector_ff <= s1_sector_ff;
         s2_sf_ff     <= prod_sf[FRAC_BITS +: FIELD_W];
         s2_st_ff     <= prod_st[FRAC_BITS +: FIELD_W];
      end
   end

   // Stage 3: the factors 1-s, 1-s*f and 1-s(1-f).
   fix_type                s3_val_ff;
   logic [SECTOR_W-1:0]    s3_sector_ff;
   fix_type                s3_kp_ff;
   fix_type                s3_kq_ff;
   fix_type                s3_kt_ff;

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         s3_val_ff    <= s2_val_ff;
         s3_sector_ff <= s2_sector_ff;
         s3_kp_ff     <= ONE_Q - s2_sat_ff;
         s3_kq_ff     <= ONE_Q - s2_sf_ff;
         s3_kt_ff     <= ONE_Q - s2_st_ff;
      end
   end

   // Stage 4: scale each factor by the value. The channel code is the product
   // times 256 with the fraction dropped, so only its top bits are kept.
   logic [PROD_W-1:0]      prod_p;
   logic [PROD_W-1:0]      prod_q;
   logic [PROD_W-1:0]      prod_t;
   logic [SECTOR_W-1:0]    s4_sector_ff;
   logic [CODE_W-1:0]      s4_cv_ff;
   logic [CODE_W-1:0]      s4_cp_ff;
   logic [CODE_W-1:0]      s4_cq_ff;
   logic [CODE_W-1:0]      s4_ct_ff;

   always_comb begin
      prod_p = PROD_W'(s3_val_ff) * PROD_W'(s3_kp_ff);
      prod_q = PROD_W'(s3_val_ff) * PROD_W'(s3_kq_ff);
      prod_t = PROD_W'(s3_val_ff) * PROD_W'(s3_kt_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         s4_sector_ff <= s3_sector_ff;
         s4_cv_ff     <= CODE_W'(s3_val_ff[FIELD_W-1:FRAC_BITS-CHAN_W]);
         s4_cp_ff     <= prod_p[PROD_W-1 -: CODE_W];
         s4_cq_ff     <= prod_q[PROD_W-1 -: CODE_W];
         s4_ct_ff     <= prod_t[PROD_W-1 -: CODE_W];
      end
   end

   // Stage 5: clip the codes to 8 bits and route them to the channels by sector.
   logic [CHAN_W-1:0]      chan_v;
   logic [CHAN_W-1:0]      chan_p;
   logic [CHAN_W-1:0]      chan_q;
   logic [CHAN_W-1:0]      chan_t;
   pixel_out_type          rgb_in;
   pixel_out_type          rsp_data_ff;

   always_comb begin
      chan_v = clip_chan(s4_cv_ff);
      chan_p = clip_chan(s4_cp_ff);
      chan_q = clip_chan(s4_cq_ff);
      chan_t = clip_chan(s4_ct_ff);
      case (s4_sector_ff)
         SECTOR_RED_TO_YELLOW: begin
            rgb_in = '{red: chan_v, green: chan_t, blue: chan_p};
         end
         SECTOR_YELLOW_TO_GREEN: begin
            rgb_in = '{red: chan_q, green: chan_v, blue: chan_p};
         end
         SECTOR_GREEN_TO_CYAN: begin
            rgb_in = '{red: chan_p, green: chan_v, blue: chan_t};
         end
         SECTOR_CYAN_TO_BLUE: begin
            rgb_in = '{red: chan_p, green: chan_q, blue: chan_v};
         end
         SECTOR_BLUE_TO_MAGENTA: begin
            rgb_in = '{red: chan_t, green: chan_p, blue: chan_v};
         end
         default: begin
            // Magenta to red; the unused sector codes never occur.
            rgb_in = '{red: chan_v, green: chan_p, blue: chan_q};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         rsp_data_ff <= rgb_in;
      end
   end

   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_data_ff;

   // The input is held off only when every stage holds a pixel.
   `ASSERT_HOLDS(a_stall_only_when_full, clock, reset, req_stall |-> (&vld_ff),
      "req stalled while the pipeline has a free stage")

   // A floored product of s with a fraction never exceeds s.
   `ASSERT_HOLDS(a_products_bounded, clock, reset,
      vld_ff[1] |-> (s2_sf_ff <= s2_sat_ff && s2_st_ff <= s2_sat_ff),
      "s*f or s*(1-f) exceeds s")

   // With zero saturation every factor is exactly one.
   `ASSERT_HOLDS(a_gray_factors, clock, reset,
      (vld_ff[2] && s3_kp_ff == ONE_Q) |-> (s3_kq_ff == ONE_Q && s3_kt_ff == ONE_Q),
      "zero saturation did not give unit factors")

   // After a result transfer with nothing behind it, no result is offered.
   `ASSERT_NEXT(a_no_phantom_result, clock, reset,
      rsp_valid && !rsp_stall && !vld_ff[NUM_STAGES-2], !rsp_valid,
      "result offered with no pixel behind it")

endmodule

`default_nettype wire
